/* hdl/mrua_pkg.sv */
// ----------------------------------------------------------------------------
// mrua_pkg: shared types and constants for the mains relay controller
// Configuration layout, item and result records, reset values.
// ----------------------------------------------------------------------------
package mrua_pkg;

    // Item kinds (carried on tuser)
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_OFF     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GUARD_ENABLE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF_MV     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_MV   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PC_ENABLE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_GRACE         = 3'd6;

    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 8;

    // Configuration reset values
    localparam logic [15:0] RST_CUTOFF_MV   = 16'd20000;
    localparam logic [15:0] RST_RECOVERY_MV = 16'd22000;
    localparam logic [15:0] RST_DEBOUNCE    = 16'd50;
    localparam logic [15:0] RST_GRACE       = 16'd3000;

    typedef struct packed {
        logic        force_off;
        logic        guard_enable;
        logic [15:0] cutoff_mv;
        logic [15:0] recovery_mv;
        logic        pc_enable;
        logic [15:0] debounce_ticks;
        logic [15:0] grace_ticks;
    } t_cfg;

    typedef struct packed {
        logic        opcode;
        logic        relay_request;
        logic [15:0] supply_mv;
        logic        pc_detect;
        logic        ota_active;
    } t_item;

    typedef struct packed {
        logic relay_on;
        logic relay_requested;
        logic undervolt_cut;
        logic pc_present;
    } t_result;

endpackage

/* hdl/mrua_ctrl.sv */
// ----------------------------------------------------------------------------
// mrua_ctrl: relay control state and per-item update
// Holds the millisecond clock, relay, undervolt and PC-detect state and
// applies one item per step.
// ----------------------------------------------------------------------------
module mrua_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  mrua_pkg::t_item i_item,
    input  mrua_pkg::t_cfg  i_cfg,
    output mrua_pkg::t_result o_res
);

    logic [31:0] r_time,      n_time;
    logic        r_relay,     n_relay;
    logic        r_req,       n_req;
    logic        r_cut,       n_cut;
    logic        r_pc_last,   n_pc_last;
    logic        r_pc_stable, n_pc_stable;
    logic [31:0] r_raw_chg,   n_raw_chg;
    logic [31:0] r_grace_end, n_grace_end;
    logic [31:0] r_off_due,   n_off_due;

    // Next state for one item
    always_comb begin
        logic [31:0] t_plus_grace;
        logic [31:0] elapsed;
        logic        pc_hold;
        n_time      = r_time;
        n_relay     = r_relay;
        n_req       = r_req;
        n_cut       = r_cut;
        n_pc_last   = r_pc_last;
        n_pc_stable = r_pc_stable;
        n_raw_chg   = r_raw_chg;
        n_grace_end = r_grace_end;
        n_off_due   = r_off_due;
        pc_hold     = !i_cfg.pc_enable || i_item.ota_active || i_cfg.force_off;
        elapsed     = '0;

        if (i_item.opcode == mrua_pkg::OP_REQUEST) begin
            // software request
            t_plus_grace = r_time + {16'd0, i_cfg.grace_ticks};
            n_req   = i_item.relay_request;
            n_relay = i_item.relay_request && !i_cfg.force_off;
            if (!n_relay)
                n_cut = 1'b0;
            if (n_relay && i_cfg.pc_enable)
                n_grace_end = t_plus_grace;
        end else begin
            n_time       = r_time + 32'd1;
            t_plus_grace = n_time + {16'd0, i_cfg.grace_ticks};

            // undervolt guard with hysteresis
            if (!i_cfg.guard_enable) begin
                n_cut   = 1'b0;
                n_relay = r_req && !i_cfg.force_off;
            end else if (!r_req) begin
                n_cut   = 1'b0;
                n_relay = 1'b0;
            end else begin
                if (!r_cut && r_relay && (i_item.supply_mv != 16'd0)
                    && (i_item.supply_mv < i_cfg.cutoff_mv)) begin
                    n_cut   = 1'b1;
                    n_relay = 1'b0;
                end
                if (n_cut && (i_item.supply_mv >= i_cfg.recovery_mv)) begin
                    n_cut   = 1'b0;
                    n_relay = !i_cfg.force_off;
                end
            end

            // PC-detect debounce and grace-period power off
            if (pc_hold) begin
                n_off_due = '0;
            end else begin
                if (i_item.pc_detect != r_pc_last) begin
                    n_pc_last = i_item.pc_detect;
                    n_raw_chg = n_time;
                end
                elapsed = n_time - n_raw_chg;
                if ((elapsed >= {16'd0, i_cfg.debounce_ticks})
                    && (i_item.pc_detect != r_pc_stable)) begin
                    n_pc_stable = i_item.pc_detect;
                    if (i_item.pc_detect) begin
                        // safe mode is off here, so the relay comes on
                        n_grace_end = t_plus_grace;
                        n_req       = 1'b1;
                        n_relay     = 1'b1;
                    end else begin
                        n_off_due = t_plus_grace;
                    end
                end
                if (!n_pc_stable && (n_off_due != 32'd0) && (n_time >= n_off_due)
                    && (n_time >= n_grace_end)) begin
                    n_req     = 1'b0;
                    n_relay   = 1'b0;
                    n_cut     = 1'b0;
                    n_off_due = '0;
                end
            end
        end

        if (i_cfg.force_off)
            n_relay = 1'b0;
    end

    assign o_res.relay_on        = n_relay && !i_cfg.force_off;
    assign o_res.relay_requested = n_req;
    assign o_res.undervolt_cut   = n_cut;
    assign o_res.pc_present      = n_pc_stable;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= '0;
            r_relay     <= 1'b0;
            r_req       <= 1'b0;
            r_cut       <= 1'b0;
            r_pc_last   <= 1'b0;
            r_pc_stable <= 1'b0;
            r_raw_chg   <= '0;
            r_grace_end <= '0;
            r_off_due   <= '0;
        end else if (i_step) begin
            r_time      <= n_time;
            r_relay     <= n_relay;
            r_req       <= n_req;
            r_cut       <= n_cut;
            r_pc_last   <= n_pc_last;
            r_pc_stable <= n_pc_stable;
            r_raw_chg   <= n_raw_chg;
            r_grace_end <= n_grace_end;
            r_off_due   <= n_off_due;
        end
    end

    // Safe mode never leaves the relay driven
    a_safe_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_cfg.force_off) |=> !r_relay)
        else $error("relay driven in safe mode");

    // Undervolt cut only stands while a request is active
    a_cut_needs_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> (!r_cut || r_req))
        else $error("undervolt cut without request");

    // Suspended PC logic cancels any pending off
    a_off_cancel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && (i_item.opcode == mrua_pkg::OP_TICK)
         && (!i_cfg.pc_enable || i_item.ota_active || i_cfg.force_off))
        |=> (r_off_due == 32'd0))
        else $error("pending off not cancelled");

endmodule

/* hdl/mains_relay_undervolt_autopower.sv */
// An accepted item waits in the input register and steps into the result
// register when the result slot is free: one item per cycle while the result
// side does not stall. The two registers form a two-stage pipe; the state
// update is combinational. Reset (synchronous, active low) clears all state,
// empties both stages and loads the configuration defaults.
// ----------------------------------------------------------------------------
// mains_relay_undervolt_autopower: mains relay controller
// Undervolt cut with hysteresis and debounced PC-detect auto power,
// streaming item in and result out, plain register write port.
// ----------------------------------------------------------------------------
module mains_relay_undervolt_autopower (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic                              i_cfg_wr_en,
    input  logic [mrua_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mrua_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // item in
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [0] relay_request, [16:1] supply_mv, [17] pc_detect, [18] ota_active
    input  logic [mrua_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // [0] opcode
    input  logic                              i_s_tuser,
    // result out
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [0] relay_on, [1] relay_requested, [2] undervolt_cut, [3] pc_present
    output logic [mrua_pkg::OUT_DATA_W-1:0]   o_m_tdata
);

    mrua_pkg::t_cfg    r_cfg;
    mrua_pkg::t_item   r_item;
    mrua_pkg::t_result w_res;
    mrua_pkg::t_result r_res;
    logic              r_in_valid;
    logic              r_out_valid;
    logic              w_step;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.force_off      <= 1'b0;
            r_cfg.guard_enable   <= 1'b1;
            r_cfg.cutoff_mv      <= mrua_pkg::RST_CUTOFF_MV;
            r_cfg.recovery_mv    <= mrua_pkg::RST_RECOVERY_MV;
            r_cfg.pc_enable      <= 1'b1;
            r_cfg.debounce_ticks <= mrua_pkg::RST_DEBOUNCE;
            r_cfg.grace_ticks    <= mrua_pkg::RST_GRACE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                mrua_pkg::REG_FORCE_OFF:    r_cfg.force_off      <= i_cfg_wdata[0];
                mrua_pkg::REG_GUARD_ENABLE: r_cfg.guard_enable   <= i_cfg_wdata[0];
                mrua_pkg::REG_CUTOFF_MV:    r_cfg.cutoff_mv      <= i_cfg_wdata;
                mrua_pkg::REG_RECOVERY_MV:  r_cfg.recovery_mv    <= i_cfg_wdata;
                mrua_pkg::REG_PC_ENABLE:    r_cfg.pc_enable      <= i_cfg_wdata[0];
                mrua_pkg::REG_DEBOUNCE:     r_cfg.debounce_ticks <= i_cfg_wdata;
                mrua_pkg::REG_GRACE:        r_cfg.grace_ticks    <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipe control: the held item steps when the result slot is free
    assign w_step     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_item.opcode        <= i_s_tuser;
            r_item.relay_request <= i_s_tdata[0];
            r_item.supply_mv     <= i_s_tdata[16:1];
            r_item.pc_detect     <= i_s_tdata[17];
            r_item.ota_active    <= i_s_tdata[18];
        end
    end

    mrua_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_item  (r_item),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step)
            r_res <= w_res;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'd0, r_res.pc_present, r_res.undervolt_cut,
                         r_res.relay_requested, r_res.relay_on};

    // A held item always reaches the empty result slot next cycle
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("held item did not advance");

    // A stalled result with a waiting item keeps the input stage full
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_tready) |=> r_in_valid)
        else $error("item lost under stall");

    // Safe mode never shows the relay on
    a_safe_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_cfg.force_off) |=> !r_res.relay_on)
        else $error("relay on in safe mode");

endmodule

/* verif/mrua_relay_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mrua_relay_checker: status predictor and compare for the relay controller
// Watches the register port and both streams. Each accepted item runs
// through a cycle-free model of the relay, undervolt and PC-detect logic.
// Each accepted result is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mrua_relay_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [mrua_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mrua_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [mrua_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic                            i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [mrua_pkg::OUT_DATA_W-1:0] i_m_tdata,
    output int                              o_failures,
    output int                              o_pending
);

    // Shadow configuration and controller state
    mrua_pkg::t_cfg cfg;
    logic [31:0] ms_now;
    logic [31:0] raw_change_at;
    logic [31:0] grace_end_at;
    logic [31:0] off_due_at;
    logic        relay_drv;
    logic        relay_req;
    logic        cut_on;
    logic        pc_raw_prev;
    logic        pc_debounced;

    // Predicted status items, oldest first
    mrua_pkg::t_result status_due[$];

    initial begin
        o_failures = 0;
        o_pending  = 0;
    end

    task automatic report_mismatch(input string field, input logic want, input logic got);
        $display("%0t ns: %s mismatch, expected %0b, got %0b", $time, field, want, got);
        o_failures++;
    endtask

    // Store a relay request and drive the relay from it
    task automatic set_request(input logic on);
        relay_req = on;
        relay_drv = on && !cfg.force_off;
        if (!relay_drv)
            cut_on = 1'b0;
        if (relay_drv && cfg.pc_enable)
            grace_end_at = ms_now + {16'd0, cfg.grace_ticks};
    endtask

    // Undervolt cut with hysteresis; a zero reading never cuts
    task automatic undervolt_guard(input logic [15:0] mv);
        if (!cfg.guard_enable) begin
            cut_on    = 1'b0;
            relay_drv = relay_req && !cfg.force_off;
            return;
        end
        if (!relay_req) begin
            cut_on    = 1'b0;
            relay_drv = 1'b0;
            return;
        end
        if (!cut_on && relay_drv && mv != 16'd0 && mv < cfg.cutoff_mv) begin
            cut_on    = 1'b1;
            relay_drv = 1'b0;
        end
        if (cut_on && mv >= cfg.recovery_mv) begin
            cut_on    = 1'b0;
            relay_drv = relay_req && !cfg.force_off;
        end
    endtask

    // PC-detect debounce and delayed power-off
    task automatic pc_auto_power(input logic raw, input logic ota);
        logic [31:0] elapsed;
        if (!cfg.pc_enable || ota || cfg.force_off) begin
            off_due_at = 32'd0;
            return;
        end
        if (raw != pc_raw_prev) begin
            pc_raw_prev   = raw;
            raw_change_at = ms_now;
        end
        elapsed = ms_now - raw_change_at;
        if (elapsed >= {16'd0, cfg.debounce_ticks} && raw != pc_debounced) begin
            pc_debounced = raw;
            if (pc_debounced) begin
                grace_end_at = ms_now + {16'd0, cfg.grace_ticks};
                set_request(1'b1);
            end else begin
                off_due_at = ms_now + {16'd0, cfg.grace_ticks};
            end
        end
        if (!pc_debounced && off_due_at != 32'd0 && ms_now >= off_due_at
                && ms_now >= grace_end_at) begin
            set_request(1'b0);
            off_due_at = 32'd0;
        end
    endtask

    // One item in, the status it leaves behind out
    task automatic predict_status(input mrua_pkg::t_item it, output mrua_pkg::t_result st);
        if (it.opcode == mrua_pkg::OP_REQUEST) begin
            set_request(it.relay_request);
        end else begin
            ms_now = ms_now + 32'd1;
            undervolt_guard(it.supply_mv);
            pc_auto_power(it.pc_detect, it.ota_active);
        end
        if (cfg.force_off)
            relay_drv = 1'b0;
        st.relay_on        = relay_drv && !cfg.force_off;
        st.relay_requested = relay_req;
        st.undervolt_cut   = cut_on;
        st.pc_present      = pc_debounced;
    endtask

    always @(posedge i_clk) begin
        mrua_pkg::t_item   it;
        mrua_pkg::t_result st;
        if (!i_rst_n) begin
            cfg.force_off      = 1'b0;
            cfg.guard_enable   = 1'b1;
            cfg.cutoff_mv      = mrua_pkg::RST_CUTOFF_MV;
            cfg.recovery_mv    = mrua_pkg::RST_RECOVERY_MV;
            cfg.pc_enable      = 1'b1;
            cfg.debounce_ticks = mrua_pkg::RST_DEBOUNCE;
            cfg.grace_ticks    = mrua_pkg::RST_GRACE;
            ms_now        = 32'd0;
            raw_change_at = 32'd0;
            grace_end_at  = 32'd0;
            off_due_at    = 32'd0;
            relay_drv     = 1'b0;
            relay_req     = 1'b0;
            cut_on        = 1'b0;
            pc_raw_prev   = 1'b0;
            pc_debounced  = 1'b0;
            status_due.delete();
        end else begin
            // register writes
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    mrua_pkg::REG_FORCE_OFF:    cfg.force_off      = i_cfg_wdata[0];
                    mrua_pkg::REG_GUARD_ENABLE: cfg.guard_enable   = i_cfg_wdata[0];
                    mrua_pkg::REG_CUTOFF_MV:    cfg.cutoff_mv      = i_cfg_wdata;
                    mrua_pkg::REG_RECOVERY_MV:  cfg.recovery_mv    = i_cfg_wdata;
                    mrua_pkg::REG_PC_ENABLE:    cfg.pc_enable      = i_cfg_wdata[0];
                    mrua_pkg::REG_DEBOUNCE:     cfg.debounce_ticks = i_cfg_wdata;
                    mrua_pkg::REG_GRACE:        cfg.grace_ticks    = i_cfg_wdata;
                    default: ;
                endcase
            end
            // result side
            if (i_m_tvalid && i_m_tready) begin
                if (status_due.size() == 0) begin
                    $display("%0t ns: status item with no prediction pending", $time);
                    o_failures++;
                end else begin
                    st = status_due.pop_front();
                    if (i_m_tdata[0] !== st.relay_on)
                        report_mismatch("relay_on", st.relay_on, i_m_tdata[0]);
                    if (i_m_tdata[1] !== st.relay_requested)
                        report_mismatch("relay_requested", st.relay_requested, i_m_tdata[1]);
                    if (i_m_tdata[2] !== st.undervolt_cut)
                        report_mismatch("undervolt_cut", st.undervolt_cut, i_m_tdata[2]);
                    if (i_m_tdata[3] !== st.pc_present)
                        report_mismatch("pc_present", st.pc_present, i_m_tdata[3]);
                end
            end
            // item side
            if (i_s_tvalid && i_s_tready) begin
                it.opcode        = i_s_tuser;
                it.relay_request = i_s_tdata[0];
                it.supply_mv     = i_s_tdata[16:1];
                it.pc_detect     = i_s_tdata[17];
                it.ota_active    = i_s_tdata[18];
                predict_status(it, st);
                status_due.push_back(st);
            end
        end
        o_pending = status_due.size();
    end

endmodule

/* verif/tb_mains_relay_undervolt_autopower.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mains_relay_undervolt_autopower: testbench top for the relay controller
// Directed items for the undervolt hysteresis, PC auto power and safe mode,
// then random tick and request streams across several register settings,
// with random gaps on the item side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_mains_relay_undervolt_autopower;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_TAIL  = 4;
    localparam int PHASE_ITEMS = 215;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_wr_en;
    logic [mrua_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [mrua_pkg::CFG_DATA_W-1:0] i_cfg_wdata;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    // [0] relay_request, [16:1] supply_mv, [17] pc_detect, [18] ota_active
    logic [mrua_pkg::IN_DATA_W-1:0]  i_s_tdata;
    // [0] opcode
    logic                            i_s_tuser;
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    // [0] relay_on, [1] relay_requested, [2] undervolt_cut, [3] pc_present
    logic [mrua_pkg::OUT_DATA_W-1:0] o_m_tdata;

    int   failures;
    int   pending;
    int   cycle_count = 0;
    int   stall_left  = 0;
    logic src_calm;
    logic sink_calm;
    logic pc_level;
    logic ota_level;
    mrua_pkg::t_cfg cur_cfg;

    mains_relay_undervolt_autopower dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    mrua_relay_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .o_failures  (failures),
        .o_pending   (pending)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Run-away guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Mostly short idle lengths, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Result side back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n || sink_calm) begin
            i_m_tready <= 1'b1;
            stall_left = 0;
        end else if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else begin
            i_m_tready <= 1'b1;
            if ($urandom_range(0, 4) == 0)
                stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                        : $urandom_range(10, 30);
        end
    end

    // Offer one item and hold it until the handshake
    task automatic send_item(input logic op, input logic req, input logic [15:0] mv,
                             input logic pc, input logic ota);
        int gap;
        gap = src_calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {5'd0, ota, pc, mv, req};
        #1;
        while (!o_s_tready) begin
            @(posedge i_clk);
            #1;
        end
        @(posedge i_clk);
    endtask

    // Stop offering and wait for every predicted status item
    task automatic drain_status();
        i_s_tvalid <= 1'b0;
        #1;
        while (pending != 0) begin
            @(posedge i_clk);
            #1;
        end
        repeat (DRAIN_TAIL) @(posedge i_clk);
    endtask

    // Write all seven registers, one per cycle
    task automatic load_config(input mrua_pkg::t_cfg c);
        logic [mrua_pkg::CFG_IDX_W-1:0]  idx [7];
        logic [mrua_pkg::CFG_DATA_W-1:0] val [7];
        int k;
        idx[0] = mrua_pkg::REG_FORCE_OFF;    val[0] = {15'd0, c.force_off};
        idx[1] = mrua_pkg::REG_GUARD_ENABLE; val[1] = {15'd0, c.guard_enable};
        idx[2] = mrua_pkg::REG_CUTOFF_MV;    val[2] = c.cutoff_mv;
        idx[3] = mrua_pkg::REG_RECOVERY_MV;  val[3] = c.recovery_mv;
        idx[4] = mrua_pkg::REG_PC_ENABLE;    val[4] = {15'd0, c.pc_enable};
        idx[5] = mrua_pkg::REG_DEBOUNCE;     val[5] = c.debounce_ticks;
        idx[6] = mrua_pkg::REG_GRACE;        val[6] = c.grace_ticks;
        for (k = 0; k < 7; k++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_wdata <= val[k];
            @(posedge i_clk);
        end
        i_cfg_wr_en <= 1'b0;
        cur_cfg = c;
    endtask

    function automatic logic [15:0] near_mv(input logic [15:0] center);
        int v;
        v = int'(center) + int'($urandom_range(0, 600)) - 300;
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[15:0];
    endfunction

    // Supply readings clustered on the thresholds, plus zero and the rails
    function automatic logic [15:0] pick_supply();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'd0;
        if (r < 18)
            return 16'hFFFF;
        if (r < 30)
            return 16'($urandom_range(0, 65535));
        if (r < 65)
            return near_mv(cur_cfg.cutoff_mv);
        return near_mv(cur_cfg.recovery_mv);
    endfunction

    // Mostly ticks with a slowly wandering PC level, some software requests
    task automatic send_random_item();
        logic pc;
        if ($urandom_range(0, 99) < 12) begin
            send_item(mrua_pkg::OP_REQUEST, 1'($urandom_range(0, 1)),
                      16'($urandom_range(0, 65535)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
            if ($urandom_range(0, 9) == 0)
                pc_level = !pc_level;
            pc = pc_level;
            if ($urandom_range(0, 29) == 0)
                pc = !pc;
            if (ota_level)
                ota_level = ($urandom_range(0, 5) != 0);
            else
                ota_level = ($urandom_range(0, 39) == 0);
            send_item(mrua_pkg::OP_TICK, 1'($urandom_range(0, 1)), pick_supply(), pc,
                      ota_level);
        end
    endtask

    // One register setting, random items, a full pause half way
    task automatic run_phase(input mrua_pkg::t_cfg c, input logic calm_src,
                             input logic calm_sink);
        int n;
        drain_status();
        load_config(c);
        src_calm  <= calm_src;
        sink_calm <= calm_sink;
        for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n == PHASE_ITEMS / 2)
                drain_status();
            send_random_item();
        end
    endtask

    function automatic mrua_pkg::t_cfg reset_cfg();
        mrua_pkg::t_cfg c;
        c.force_off      = 1'b0;
        c.guard_enable   = 1'b1;
        c.cutoff_mv      = mrua_pkg::RST_CUTOFF_MV;
        c.recovery_mv    = mrua_pkg::RST_RECOVERY_MV;
        c.pc_enable      = 1'b1;
        c.debounce_ticks = mrua_pkg::RST_DEBOUNCE;
        c.grace_ticks    = mrua_pkg::RST_GRACE;
        return c;
    endfunction

    initial begin
        mrua_pkg::t_cfg c;
        int   k;
        i_rst_n     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= mrua_pkg::REG_FORCE_OFF;
        i_cfg_wdata <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= mrua_pkg::OP_TICK;
        i_m_tready  <= 1'b0;
        src_calm    <= 1'b0;
        sink_calm   <= 1'b0;
        pc_level    = 1'b0;
        ota_level   = 1'b0;
        cur_cfg     = reset_cfg();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: undervolt cut, zero reading, recovery, no request
        send_item(mrua_pkg::OP_REQUEST, 1'b1, 16'd0, 1'b0, 1'b0);
        send_item(mrua_pkg::OP_TICK, 1'b0, 16'hFFFF, 1'b0, 1'b0);
        send_item(mrua_pkg::OP_TICK, 1'b0, 16'd19999, 1'b0, 1'b0);
        send_item(mrua_pkg::OP_TICK, 1'b0, 16'd0, 1'b0, 1'b0);
        send_item(mrua_pkg::OP_TICK, 1'b0, 16'd21999, 1'b0, 1'b0);
        send_item(mrua_pkg::OP_TICK, 1'b0, 16'd22000, 1'b0, 1'b0);
        send_item(mrua_pkg::OP_REQUEST, 1'b0, 16'hFFFF, 1'b1, 1'b1);
        send_item(mrua_pkg::OP_TICK, 1'b1, 16'd10000, 1'b0, 1'b0);

        // Short debounce and grace: PC on, OTA freeze, PC off after grace
        c = reset_cfg();
        c.debounce_ticks = 16'd2;
        c.grace_ticks    = 16'd3;
        drain_status();
        load_config(c);
        for (k = 0; k < 4; k++)
            send_item(mrua_pkg::OP_TICK, 1'b0, 16'd30000, 1'b1, 1'b0);
        send_item(mrua_pkg::OP_TICK, 1'b0, 16'd30000, 1'b1, 1'b1);
        for (k = 0; k < 7; k++)
            send_item(mrua_pkg::OP_TICK, 1'b0, 16'd30000, 1'b0, 1'b0);
        send_item(mrua_pkg::OP_REQUEST, 1'b1, 16'd0, 1'b0, 1'b0);

        // Safe mode holds the relay off
        c.force_off = 1'b1;
        drain_status();
        load_config(c);
        send_item(mrua_pkg::OP_REQUEST, 1'b1, 16'd0, 1'b0, 1'b0);
        send_item(mrua_pkg::OP_TICK, 1'b1, 16'd30000, 1'b1, 1'b0);
        send_item(mrua_pkg::OP_REQUEST, 1'b0, 16'd0, 1'b0, 1'b0);

        // Random phases over a spread of settings
        c = reset_cfg();
        c.debounce_ticks = 16'd3;
        c.grace_ticks    = 16'd10;
        run_phase(c, 1'b0, 1'b0);

        c.cutoff_mv      = 16'hFFFF;
        c.recovery_mv    = 16'hFFFF;
        c.debounce_ticks = 16'd0;
        c.grace_ticks    = 16'd0;
        run_phase(c, 1'b1, 1'b0);

        // Zero thresholds: a zero reading still counts toward recovery
        c.cutoff_mv      = 16'd0;
        c.recovery_mv    = 16'd0;
        c.debounce_ticks = 16'd1;
        c.grace_ticks    = 16'd5;
        run_phase(c, 1'b0, 1'b1);

        c = reset_cfg();
        c.guard_enable   = 1'b0;
        c.debounce_ticks = 16'd5;
        c.grace_ticks    = 16'd20;
        run_phase(c, 1'b0, 1'b0);

        c.guard_enable = 1'b1;
        c.force_off    = 1'b1;
        run_phase(c, 1'b1, 1'b0);

        c.force_off = 1'b0;
        c.pc_enable = 1'b0;
        run_phase(c, 1'b0, 1'b1);

        c = reset_cfg();
        c.debounce_ticks = 16'hFFFF;
        c.grace_ticks    = 16'hFFFF;
        run_phase(c, 1'b0, 1'b0);

        c.force_off      = ($urandom_range(0, 3) == 0);
        c.guard_enable   = 1'($urandom_range(0, 1));
        c.cutoff_mv      = 16'($urandom_range(0, 65535));
        c.recovery_mv    = 16'($urandom_range(0, 65535));
        c.pc_enable      = ($urandom_range(0, 3) != 0);
        c.debounce_ticks = 16'($urandom_range(0, 8));
        c.grace_ticks    = 16'($urandom_range(0, 30));
        run_phase(c, 1'b0, 1'b0);

        run_phase(reset_cfg(), 1'b0, 1'b0);

        drain_status();
        repeat (8) @(posedge i_clk);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
hdl/mrua_pkg.sv
hdl/mrua_ctrl.sv
hdl/mains_relay_undervolt_autopower.sv
verif/mrua_relay_checker.sv
verif/tb_mains_relay_undervolt_autopower.sv
